@@ sv/geb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gershgorin bound package
// Shared types, constants and saturating arithmetic helpers for the
// Gershgorin eigenvalue bound block and its divider.
// ----------------------------------------------------------------------------
package geb_pkg;

  // Widths
  localparam int ROW_INDEX_BITS = 20;
  localparam int COL_W          = 20;
  localparam int Q_W            = 32;
  localparam int FRAC_W         = 16;
  localparam int DIV_W          = Q_W + FRAC_W;
  localparam int DIV_CNT_W      = $clog2(DIV_W + 1);

  localparam logic signed [Q_W-1:0] Q_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [Q_W-1:0] Q_MIN  = 32'sh8000_0000;
  localparam logic signed [Q_W-1:0] Q_ZERO = 32'sh0000_0000;

  // Input transaction
  typedef struct packed {
    logic signed [Q_W-1:0] entry_value;
    logic [COL_W-1:0]      column_index;
    logic                  from_offd_part;
    logic                  has_entry;
    logic                  row_end;
    logic                  matrix_end;
  } geb_in_t;

  // Result transaction
  typedef struct packed {
    logic [19:0]           row_number;
    logic signed [Q_W-1:0] row_lower;
    logic signed [Q_W-1:0] row_upper;
    logic                  zero_diagonal;
    logic signed [Q_W-1:0] estimate_min;
    logic signed [Q_W-1:0] estimate_max;
    logic                  estimate_done;
  } geb_out_t;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [Q_W-1:0]   numer;
    logic [Q_W-1:0]   denom;
  } geb_div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quot;
  } geb_div_rsp_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_BND_LO,
    S_BND_HI,
    S_LO_GO,
    S_LO_WAIT,
    S_HI_GO,
    S_HI_WAIT,
    S_MINMAX,
    S_EMIT
  } geb_state_t;

  // Saturating signed add
  function automatic logic signed [Q_W-1:0] sat_add(input logic signed [Q_W-1:0] a,
                                                    input logic signed [Q_W-1:0] b);
    logic signed [Q_W:0] s;
    s = {a[Q_W-1], a} + {b[Q_W-1], b};
    if (s[Q_W] != s[Q_W-1]) begin
      return s[Q_W] ? Q_MIN : Q_MAX;
    end
    return s[Q_W-1:0];
  endfunction

  // Absolute value, most negative value saturates
  function automatic logic signed [Q_W-1:0] abs_sat(input logic signed [Q_W-1:0] a);
    if (a == Q_MIN) begin
      return Q_MAX;
    end
    return a[Q_W-1] ? Q_ZERO - a : a;
  endfunction

  // Exact unsigned magnitude
  function automatic logic [Q_W-1:0] umag(input logic signed [Q_W-1:0] a);
    return a[Q_W-1] ? (~a + 1'b1) : a;
  endfunction

  // Push a nonzero value to the rail of its sign
  function automatic logic signed [Q_W-1:0] sign_sat(input logic signed [Q_W-1:0] a);
    if (a == Q_ZERO) begin
      return Q_ZERO;
    end
    return a[Q_W-1] ? Q_MIN : Q_MAX;
  endfunction

  // Apply the sign to a quotient magnitude and saturate
  function automatic logic signed [Q_W-1:0] quot_sat(input logic [DIV_W-1:0] q,
                                                     input logic neg);
    logic [DIV_W-1:0] qn;
    qn = ~q + 1'b1;
    if (!neg) begin
      return (q > DIV_W'(32'h7FFF_FFFF)) ? Q_MAX : q[Q_W-1:0];
    end
    return (q > DIV_W'(32'h8000_0000)) ? Q_MIN : qn[Q_W-1:0];
  endfunction

endpackage

@@ sv/geb_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gershgorin bound divider
// Restoring radix-2 divider: (numer * 2^16) / denom, one quotient bit per
// cycle, unsigned magnitudes in, full-width quotient out.
// ----------------------------------------------------------------------------
module geb_div import geb_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  geb_div_req_t req,
  output geb_div_rsp_t rsp
);

  logic [DIV_W-1:0]     q_r;
  logic [DIV_W-1:0]     q_nxt;
  logic [Q_W-1:0]       rem_r;
  logic [Q_W-1:0]       rem_nxt;
  logic [Q_W-1:0]       den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [Q_W:0]         rem_sh;
  logic                 ge;

  // Shift in the next dividend bit and try to subtract
  always_comb begin
    rem_sh  = {rem_r, q_r[DIV_W-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_nxt = ge ? Q_W'(rem_sh - {1'b0, den_r}) : rem_sh[Q_W-1:0];
    q_nxt   = {q_r[DIV_W-2:0], ge};
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r   <= {req.numer, FRAC_W'(0)};
      rem_r <= '0;
      den_r <= req.denom;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = q_r;

  // Never restart a division in flight
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r) else $error("divider started while busy");

  // Done follows the last iteration
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (!busy_r && $past(busy_r))) else $error("divider done without a run");

endmodule

@@ sv/gershgorin_eigen_bound.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gershgorin eigenvalue bound
// Streams sparse matrix rows in Q16.16, forms per-row Gershgorin bounds,
// optionally scales them by the diagonal, and folds running extrema into
// eigenvalue estimates at matrix end.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+---------------------------
//  cfg     | in  | cfg_valid/cfg_ready  | cfg_data (scale_by_diagonal)
//  in      | in  | in_valid/in_ready    | in_data  (geb_in_t)
//  out     | out | out_valid/out_ready  | out_data (geb_out_t)
//
// Items are taken only in S_IDLE. A row end then steps through S_BND_LO,
// S_BND_HI, S_MINMAX and S_EMIT; with scaling and a nonzero diagonal, the
// shared divider runs once per bound (48 quotient bits) before S_MINMAX.
// Bound sums use one saturating adder and divisions one radix-2 divider.
// Reset is synchronous, active low; it clears the accumulators and counters.
// A result waits in the output register while the next items are taken; a
// further row end stalls only if that register is still full.
// ----------------------------------------------------------------------------
module gershgorin_eigen_bound import geb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     cfg_data,
  input  logic     in_valid,
  output logic     in_ready,
  input  geb_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output geb_out_t out_data
);

  localparam int CMP_W = (ROW_INDEX_BITS > COL_W) ? ROW_INDEX_BITS : COL_W;

  geb_state_t state_r, state_nxt;

  logic                      scale_r;
  logic signed [Q_W-1:0]     diag_r;
  logic signed [Q_W-1:0]     offd_r;
  logic [ROW_INDEX_BITS-1:0] row_r;
  logic signed [Q_W-1:0]     run_min_r;
  logic signed [Q_W-1:0]     run_max_r;
  logic signed [Q_W-1:0]     lower_r;
  logic signed [Q_W-1:0]     upper_r;
  logic                      mend_r;
  logic                      out_valid_r;
  geb_out_t                  out_data_r;

  logic                  in_fire;
  logic                  diag_hit;
  logic                  zero_diag;
  logic                  emit_ok;
  logic signed [Q_W-1:0] add_a;
  logic signed [Q_W-1:0] add_b;
  logic signed [Q_W-1:0] add_sum;
  logic                  fold_gt;
  logic signed [Q_W-1:0] est_min;
  logic signed [Q_W-1:0] est_max;

  geb_div_req_t div_req;
  geb_div_rsp_t div_rsp;

  // Shared divider
  geb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_fire   = in_valid && in_ready;
  assign diag_hit  = !in_data.from_offd_part &&
                     (CMP_W'(in_data.column_index) == CMP_W'(row_r));
  assign zero_diag = scale_r && (diag_r == Q_ZERO);

  // Steer the shared saturating adder
  always_comb begin
    add_a = diag_r;
    add_b = offd_r;
    case (state_r)
      S_IDLE: begin
        if (diag_hit) begin
          add_a = diag_r;
          add_b = in_data.entry_value;
        end else begin
          add_a = offd_r;
          add_b = abs_sat(in_data.entry_value);
        end
      end
      S_BND_LO: begin
        add_a = diag_r;
        add_b = Q_ZERO - offd_r;
      end
      default: begin
        add_a = diag_r;
        add_b = offd_r;
      end
    endcase
    add_sum = sat_add(add_a, add_b);
  end

  // Fold the running extrema into estimates
  always_comb begin
    fold_gt = umag(run_min_r) > umag(run_max_r);
    est_min = Q_ZERO;
    est_max = Q_ZERO;
    if (mend_r) begin
      if (fold_gt) begin
        est_min = run_min_r;
        est_max = (run_max_r < Q_ZERO) ? run_max_r : Q_ZERO;
      end else begin
        est_min = (run_min_r > Q_ZERO) ? run_min_r : Q_ZERO;
        est_max = run_max_r;
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_fire && in_data.row_end) state_nxt = S_BND_LO;
      S_BND_LO:  state_nxt = S_BND_HI;
      S_BND_HI:  state_nxt = (scale_r && !zero_diag) ? S_LO_GO : S_MINMAX;
      S_LO_GO:   state_nxt = S_LO_WAIT;
      S_LO_WAIT: if (div_rsp.done) state_nxt = S_HI_GO;
      S_HI_GO:   state_nxt = S_HI_WAIT;
      S_HI_WAIT: if (div_rsp.done) state_nxt = S_MINMAX;
      S_MINMAX:  state_nxt = S_EMIT;
      S_EMIT:    if (emit_ok) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready      = (state_r == S_IDLE);
    emit_ok       = (state_r == S_EMIT) && (!out_valid_r || out_ready);
    div_req.start = (state_r == S_LO_GO) || (state_r == S_HI_GO);
    div_req.numer = (state_r == S_HI_GO) ? umag(upper_r) : umag(lower_r);
    div_req.denom = umag(diag_r);
  end

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Control and accumulator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scale_r     <= 1'b0;
      diag_r      <= Q_ZERO;
      offd_r      <= Q_ZERO;
      row_r       <= '0;
      run_min_r   <= Q_ZERO;
      run_max_r   <= Q_ZERO;
      mend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        scale_r <= cfg_data;
      end

      // Accumulate the entry of an accepted transaction
      if (in_fire) begin
        mend_r <= in_data.matrix_end;
        if (in_data.has_entry) begin
          if (diag_hit) begin
            diag_r <= add_sum;
          end else begin
            offd_r <= add_sum;
          end
        end
      end

      // Track the extrema
      if (state_r == S_MINMAX) begin
        if (lower_r < run_min_r) run_min_r <= lower_r;
        if (upper_r > run_max_r) run_max_r <= upper_r;
      end

      // Close the row
      if (emit_ok) begin
        diag_r <= Q_ZERO;
        offd_r <= Q_ZERO;
        if (mend_r) begin
          row_r     <= '0;
          run_min_r <= Q_ZERO;
          run_max_r <= Q_ZERO;
        end else begin
          row_r <= row_r + 1'b1;
        end
      end

      // Hold the result until taken
      if (emit_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Row bounds and result register
  always_ff @(posedge clk) begin
    case (state_r)
      S_BND_LO:  lower_r <= zero_diag ? sign_sat(add_sum) : add_sum;
      S_BND_HI:  upper_r <= zero_diag ? sign_sat(add_sum) : add_sum;
      S_LO_WAIT: if (div_rsp.done) lower_r <= quot_sat(div_rsp.quot, lower_r[Q_W-1]);
      S_HI_WAIT: if (div_rsp.done) upper_r <= quot_sat(div_rsp.quot, upper_r[Q_W-1]);
      default: begin
      end
    endcase
    if (emit_ok) begin
      out_data_r.row_number    <= 20'(row_r);
      out_data_r.row_lower     <= lower_r;
      out_data_r.row_upper     <= upper_r;
      out_data_r.zero_diagonal <= zero_diag;
      out_data_r.estimate_min  <= est_min;
      out_data_r.estimate_max  <= est_max;
      out_data_r.estimate_done <= mend_r;
    end
  end

  // Off-diagonal sum never goes negative
  a_offd_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    !offd_r[Q_W-1]) else $error("off-diagonal sum negative");

  // Running extrema stay on their side of zero
  a_extrema_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (run_min_r <= Q_ZERO) && (run_max_r >= Q_ZERO)) else $error("extrema crossed zero");

  // Matrix end clears the row counter and extrema
  a_matrix_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_ok && mend_r) |=> (row_r == '0 && run_min_r == Q_ZERO && run_max_r == Q_ZERO))
    else $error("state not cleared after matrix end");

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gershgorin eigenvalue bound testbench
// Streams directed and random sparse matrix rows into the bound block, with
// and without diagonal scaling, and checks every row result against a
// Q16.16 bound calculator kept in the bench. Both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import geb_pkg::*;

  localparam longint QHI = 64'sd2147483647;
  localparam longint QLO = -64'sd2147483648;
  localparam int unsigned SETTLE = 150;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned PHASE_ITEMS = 280;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic     cfg_data = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  geb_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  geb_out_t out_data;

  gershgorin_eigen_bound dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stream of items waiting for the driver, and row bounds still owed by the block
  geb_in_t  nz_stream[$];
  geb_out_t due_bounds[$];

  // Bound calculator state
  logic                      scale_on = 1'b0;
  longint                    diag_sum = 0;
  longint                    abs_sum = 0;
  logic [ROW_INDEX_BITS-1:0] bound_row = '0;
  longint                    low_extreme = 0;
  longint                    high_extreme = 0;

  // Stimulus bookkeeping
  logic [ROW_INDEX_BITS-1:0] gen_row = '0;
  int unsigned items_queued = 0;
  int unsigned items_taken = 0;
  int unsigned useful_items = 0;
  int unsigned rows_checked = 0;
  int unsigned zero_diag_rows = 0;
  int unsigned matrices_closed = 0;
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;

  // Handshake flags, set at the rising edge and read at the falling edge
  bit in_taken = 1'b0;
  bit out_taken = 1'b0;
  bit cfg_taken = 1'b0;

  // Idling state for each side
  int unsigned in_gap = 0;
  int unsigned out_wait = 0;
  bit          in_burst = 1'b0;
  bit          out_burst = 1'b0;

  function automatic longint clamp_q(input longint x);
    if (x > QHI) return QHI;
    if (x < QLO) return QLO;
    return x;
  endfunction

  // Draw a random wait; now and then flip into or out of a no-wait stretch
  function automatic int unsigned draw_wait(inout bit burst);
    if ($urandom_range(0, 39) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 10);
  endfunction

  // Accumulate one item; return 1 with the row bounds when the row closes
  function automatic bit gershgorin_row(input geb_in_t it, output geb_out_t res);
    longint v, d, s, lo, hi, mag, fmin, fmax;
    res = '0;
    if (it.has_entry) begin
      v = $signed(it.entry_value);
      if (!it.from_offd_part && it.column_index == bound_row)
        diag_sum = clamp_q(diag_sum + v);
      else
        abs_sum = clamp_q(abs_sum + clamp_q(v < 0 ? -v : v));
    end
    if (!it.row_end) return 1'b0;

    d  = diag_sum;
    s  = abs_sum;
    lo = clamp_q(d - s);
    hi = clamp_q(d + s);
    if (scale_on) begin
      if (d == 0) begin
        // No diagonal to divide by: push each bound to the rail of its sign
        res.zero_diagonal = 1'b1;
        lo = lo > 0 ? QHI : (lo < 0 ? QLO : 0);
        hi = hi > 0 ? QHI : (hi < 0 ? QLO : 0);
      end else begin
        mag = d < 0 ? -d : d;
        lo  = clamp_q((lo * 65536) / mag);
        hi  = clamp_q((hi * 65536) / mag);
      end
    end
    if (lo < low_extreme) low_extreme = lo;
    if (hi > high_extreme) high_extreme = hi;

    // Fold the extremes on the last row of the matrix
    fmin = 0;
    fmax = 0;
    if (it.matrix_end) begin
      if ((low_extreme < 0 ? -low_extreme : low_extreme) >
          (high_extreme < 0 ? -high_extreme : high_extreme)) begin
        fmin = low_extreme;
        fmax = high_extreme < 0 ? high_extreme : 0;
      end else begin
        fmin = low_extreme > 0 ? low_extreme : 0;
        fmax = high_extreme;
      end
    end

    res.row_number    = bound_row[19:0];
    res.row_lower     = lo[31:0];
    res.row_upper     = hi[31:0];
    res.estimate_min  = fmin[31:0];
    res.estimate_max  = fmax[31:0];
    res.estimate_done = it.matrix_end;

    // Clear the row; start a fresh matrix after its last row
    diag_sum = 0;
    abs_sum  = 0;
    if (it.matrix_end) begin
      bound_row    = '0;
      low_extreme  = 0;
      high_extreme = 0;
    end else begin
      bound_row = bound_row + 1'b1;
    end
    return 1'b1;
  endfunction

  task automatic flag_field(input string name, input longint want, input longint got);
    $error("%s: expected %0d, got %0d", name, want, got);
    fail_count++;
  endtask

  // Sample handshakes, predict, check and watch for a hang
  always @(posedge clk) begin
    geb_out_t want;
    in_taken  = rst_n && in_valid && in_ready;
    out_taken = rst_n && out_valid && out_ready;
    cfg_taken = rst_n && cfg_valid && cfg_ready;

    if (in_taken) begin
      items_taken++;
      if (gershgorin_row(in_data, want)) due_bounds.push_back(want);
    end

    if (out_taken) begin
      if (due_bounds.size() == 0) begin
        $error("unexpected result for row %0d", out_data.row_number);
        fail_count++;
      end else begin
        want = due_bounds.pop_front();
        rows_checked++;
        if (want.zero_diagonal) zero_diag_rows++;
        if (want.estimate_done) matrices_closed++;
        if (out_data.row_number !== want.row_number)
          flag_field("row_number", want.row_number, out_data.row_number);
        if (out_data.row_lower !== want.row_lower)
          flag_field("row_lower", $signed(want.row_lower), $signed(out_data.row_lower));
        if (out_data.row_upper !== want.row_upper)
          flag_field("row_upper", $signed(want.row_upper), $signed(out_data.row_upper));
        if (out_data.zero_diagonal !== want.zero_diagonal)
          flag_field("zero_diagonal", want.zero_diagonal, out_data.zero_diagonal);
        if (out_data.estimate_min !== want.estimate_min)
          flag_field("estimate_min", $signed(want.estimate_min),
                     $signed(out_data.estimate_min));
        if (out_data.estimate_max !== want.estimate_max)
          flag_field("estimate_max", $signed(want.estimate_max),
                     $signed(out_data.estimate_max));
        if (out_data.estimate_done !== want.estimate_done)
          flag_field("estimate_done", want.estimate_done, out_data.estimate_done);
      end
    end

    // Watchdog: stop if no transaction moves for too long
    if (rst_n) begin
      if (in_taken || out_taken || cfg_taken) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Input driver: hold until accepted, then wait the drawn gap and present the next item
  always @(negedge clk) begin
    logic nxt_valid;
    if (rst_n && !(in_valid && !in_taken)) begin
      nxt_valid = 1'b0;
      if (in_gap != 0) begin
        in_gap--;
      end else if (nz_stream.size() != 0) begin
        in_data  <= nz_stream.pop_front();
        nxt_valid = 1'b1;
        in_gap    = draw_wait(in_burst);
      end
      in_valid <= nxt_valid;
    end
  end

  // Result receiver: stall a drawn number of cycles after each result
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) out_wait = draw_wait(out_burst);
      if (out_wait != 0) begin
        out_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic geb_in_t mk_item(input logic signed [31:0] value,
                                      input logic [COL_W-1:0] col,
                                      input logic offd, input logic has,
                                      input logic re, input logic me);
    geb_in_t it;
    it.entry_value    = value;
    it.column_index   = col;
    it.from_offd_part = offd;
    it.has_entry      = has;
    it.row_end        = re;
    it.matrix_end     = me;
    return it;
  endfunction

  // Queue an item and track the row number the block will be on
  task automatic push_item(input geb_in_t it);
    nz_stream.push_back(it);
    items_queued++;
    if (it.has_entry || it.row_end) useful_items++;
    if (it.row_end) gen_row = it.matrix_end ? '0 : gen_row + 1'b1;
  endtask

  function automatic logic signed [31:0] rand_value();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0:       v = Q_MAX;
      1:       v = Q_MIN;
      2:       v = Q_ZERO;
      3:       v = $urandom_range(0, 32'h3FFFF);
      4:       v = $urandom;
      default: v = $urandom_range(0, 32'h000F_FFFF);
    endcase
    if (v != Q_MIN && $urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  function automatic logic [COL_W-1:0] pick_column();
    case ($urandom_range(0, 5))
      0, 1:    return gen_row[COL_W-1:0];
      2, 3:    return COL_W'($urandom_range(0, 15));
      default: return COL_W'($urandom_range(0, (1 << COL_W) - 1));
    endcase
  endfunction

  // One matrix: mostly well formed, with stray items and now and then no closing row
  task automatic add_random_matrix();
    int unsigned rows, ents;
    bit closes, merged, last_row;
    rows   = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
    closes = $urandom_range(0, 9) != 0;
    for (int unsigned r = 0; r < rows; r++) begin
      ents     = $urandom_range(0, 5);
      merged   = 1'b0;
      last_row = closes && (r == rows - 1);
      for (int unsigned e = 0; e < ents; e++) begin
        // Stray items: an empty slot, or a matrix end that does not close a row
        if ($urandom_range(0, 11) == 0)
          push_item(mk_item($urandom, COL_W'($urandom_range(0, (1 << COL_W) - 1)),
                            1'($urandom_range(0, 1)), 1'b0, 1'b0,
                            1'($urandom_range(0, 1))));
        if ($urandom_range(0, 29) == 0)
          push_item(mk_item(rand_value(), pick_column(), 1'b0,
                            1'($urandom_range(0, 1)), 1'b0, 1'b1));
        merged = (e == ents - 1) && $urandom_range(0, 1);
        push_item(mk_item(rand_value(), pick_column(), $urandom_range(0, 4) == 0,
                          1'b1, merged, merged && last_row));
      end
      if (!merged)
        push_item(mk_item($urandom, COL_W'($urandom_range(0, (1 << COL_W) - 1)),
                          1'($urandom_range(0, 1)), 1'b0, 1'b1, last_row));
    end
  endtask

  // Write the scaling register; only called while the block is idle
  task automatic write_scale(input logic v);
    @(negedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    scale_on = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold the sender until every queued item is taken and every row result is back
  task automatic wait_drained();
    while (items_taken != items_queued || due_bounds.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    int unsigned target;
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed, no scaling: saturating sums, off-part column on the diagonal,
    // empty slot, matrix end without row end, bare row end, duplicate diagonal
    write_scale(1'b0);
    @(posedge clk);
    push_item(mk_item(Q_MAX, 0, 1'b0, 1'b1, 1'b0, 1'b0));
    push_item(mk_item(Q_MIN, 5, 1'b0, 1'b1, 1'b0, 1'b0));
    push_item(mk_item(Q_MIN, 0, 1'b1, 1'b1, 1'b0, 1'b0));
    push_item(mk_item(32'sh0001_0000, 20'hFFFFF, 1'b0, 1'b1, 1'b0, 1'b0));
    push_item(mk_item(-32'sd1, 3, 1'b0, 1'b1, 1'b1, 1'b0));
    push_item(mk_item(32'sd123, 1, 1'b0, 1'b0, 1'b0, 1'b0));
    push_item(mk_item(Q_MAX, 1, 1'b0, 1'b1, 1'b0, 1'b1));
    push_item(mk_item(Q_ZERO, 0, 1'b0, 1'b0, 1'b1, 1'b0));
    push_item(mk_item(32'sh0001_0000, 2, 1'b0, 1'b1, 1'b0, 1'b0));
    push_item(mk_item(32'sh0001_0000, 2, 1'b0, 1'b1, 1'b0, 1'b0));
    push_item(mk_item(-32'sh0003_0000, 7, 1'b0, 1'b1, 1'b1, 1'b1));
    wait_drained();

    // Directed, scaling on: zero diagonal, tiny diagonal, negative and
    // most negative diagonal, then a small all-positive matrix
    write_scale(1'b1);
    @(posedge clk);
    push_item(mk_item(32'sh0000_8000, 4, 1'b0, 1'b1, 1'b1, 1'b0));
    push_item(mk_item(Q_ZERO, 0, 1'b0, 1'b0, 1'b1, 1'b0));
    push_item(mk_item(32'sd1, 2, 1'b0, 1'b1, 1'b0, 1'b0));
    push_item(mk_item(Q_MAX, 9, 1'b1, 1'b1, 1'b1, 1'b0));
    push_item(mk_item(-32'sh0002_0000, 3, 1'b0, 1'b1, 1'b0, 1'b0));
    push_item(mk_item(32'sh0000_8000, 0, 1'b0, 1'b1, 1'b1, 1'b0));
    push_item(mk_item(Q_MIN, 4, 1'b0, 1'b1, 1'b0, 1'b0));
    push_item(mk_item(-32'sd1, 4, 1'b0, 1'b1, 1'b0, 1'b0));
    push_item(mk_item(Q_ZERO, 0, 1'b0, 1'b0, 1'b1, 1'b1));
    push_item(mk_item(32'sh0003_0000, 0, 1'b0, 1'b1, 1'b1, 1'b0));
    push_item(mk_item(32'sh0001_0000, 1, 1'b0, 1'b1, 1'b1, 1'b1));
    wait_drained();

    // Random phases, alternating the scaling register
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      write_scale(p % 2 == 0);
      @(posedge clk);
      target = useful_items + PHASE_ITEMS;
      while (useful_items < target) add_random_matrix();
      wait_drained();
    end

    $display("Covered %0d items, %0d row results (%0d with zero diagonal), %0d matrices",
             items_taken, rows_checked, zero_diag_rows, matrices_closed);
    $display("Scaling register taken through both values over %0d phases",
             RANDOM_PHASES + 2);
    if (fail_count == 0 && due_bounds.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/geb_pkg.sv
sv/geb_div.sv
sv/gershgorin_eigen_bound.sv
bench/testbench.sv
